FILE: rtl/rptw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rptw_pkg;

    // Table geometry and field widths
    localparam int IDX_W     = 9;
    localparam int ENTRIES   = 512;
    localparam int VP_W      = 45;
    localparam int TF_W      = 52;
    localparam int ENT_W     = TF_W + 1;   // stored entry: {frame, valid}
    localparam int LVL_W     = 3;
    localparam int PC_W      = 4;
    localparam int NF_W      = 7;
    localparam int ROOT_W    = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 7;
    localparam int NF_CAP    = 127;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROOT_FRAME = 1'b0,
        CFG_FIRST_FREE = 1'b1
    } t_cfg_idx;

    typedef enum logic [0:0] {
        CMD_QUERY  = 1'b0,
        CMD_UPDATE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_MAPPED = 2'd1,
        ST_NO_FRAMES  = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd              command;
        logic [VP_W-1:0]   virtual_page;
        logic [TF_W-1:0]   target_frame;
        logic              unmap;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [TF_W-1:0]   result_frame;
    } t_rsp;

    // Jump conditions tested by the sequencer
    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_SWEEP_ALL_MORE,
        C_SWEEP_ROW_MORE,
        C_BAD,
        C_AT_LEAF,
        C_RD_VALID,
        C_NOT_MAP,
        C_NO_ROOM,
        C_MORE_INNER,
        C_IS_QUERY
    } t_cond;

    // Memory port operations
    typedef enum logic [2:0] {
        M_NONE,
        M_READ,
        M_CLR_ALL,
        M_CLR_ROW,
        M_LINK,
        M_LEAF
    } t_memop;

    // Datapath register operations
    typedef enum logic [3:0] {
        D_NONE,
        D_LOAD_REQ,
        D_SWEEP_INC,
        D_LOAD_ENTRY,
        D_ALLOC,
        D_LINK_ADV,
        D_SET_HIT,
        D_SET_OK,
        D_SET_NM,
        D_SET_OOF
    } t_dpop;

    typedef struct packed {
        t_cond             cond;
        logic [PC_W-1:0]   target;
        t_memop            mem;
        t_dpop             dp;
        logic              rdy;
        logic              fin;
    } t_uword;

    typedef struct packed {
        logic accept;
        logic sweep_all_more;
        logic sweep_row_more;
        logic bad;
        logic at_leaf;
        logic rd_valid;
        logic not_map;
        logic no_room;
        logic more_inner;
        logic is_query;
        logic out_busy;
    } t_flags;

    // Program steps
    localparam logic [PC_W-1:0] PC_CLEAR     = 4'd0;
    localparam logic [PC_W-1:0] PC_IDLE      = 4'd1;
    localparam logic [PC_W-1:0] PC_CHK_BAD   = 4'd2;
    localparam logic [PC_W-1:0] PC_CHK_LEAF  = 4'd3;
    localparam logic [PC_W-1:0] PC_WALK_EVAL = 4'd4;
    localparam logic [PC_W-1:0] PC_MISS      = 4'd5;
    localparam logic [PC_W-1:0] PC_ROOM      = 4'd6;
    localparam logic [PC_W-1:0] PC_ALLOC     = 4'd7;
    localparam logic [PC_W-1:0] PC_SWEEP     = 4'd8;
    localparam logic [PC_W-1:0] PC_LINK      = 4'd9;
    localparam logic [PC_W-1:0] PC_LEAF      = 4'd10;
    localparam logic [PC_W-1:0] PC_UPD       = 4'd11;
    localparam logic [PC_W-1:0] PC_NM        = 4'd12;
    localparam logic [PC_W-1:0] PC_OOF       = 4'd13;
    localparam logic [PC_W-1:0] PC_FIN       = 4'd14;

    function automatic t_uword uw(input t_cond c, input logic [PC_W-1:0] tgt,
                                  input t_memop m, input t_dpop d,
                                  input logic rdy, input logic fin);
        t_uword w;
        w.cond   = c;
        w.target = tgt;
        w.mem    = m;
        w.dp     = d;
        w.rdy    = rdy;
        w.fin    = fin;
        return w;
    endfunction

    // Control store: one word per step
    function automatic t_uword ucode_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            PC_CLEAR:     w = uw(C_SWEEP_ALL_MORE, PC_CLEAR, M_CLR_ALL, D_SWEEP_INC, 1'b0, 1'b0);
            PC_IDLE:      w = uw(C_NO_ACCEPT, PC_IDLE, M_NONE, D_LOAD_REQ, 1'b1, 1'b0);
            PC_CHK_BAD:   w = uw(C_BAD, PC_NM, M_NONE, D_NONE, 1'b0, 1'b0);
            PC_CHK_LEAF:  w = uw(C_AT_LEAF, PC_LEAF, M_READ, D_NONE, 1'b0, 1'b0);
            PC_WALK_EVAL: w = uw(C_RD_VALID, PC_CHK_BAD, M_NONE, D_LOAD_ENTRY, 1'b0, 1'b0);
            PC_MISS:      w = uw(C_NOT_MAP, PC_NM, M_NONE, D_NONE, 1'b0, 1'b0);
            PC_ROOM:      w = uw(C_NO_ROOM, PC_OOF, M_NONE, D_NONE, 1'b0, 1'b0);
            PC_ALLOC:     w = uw(C_NONE, PC_IDLE, M_NONE, D_ALLOC, 1'b0, 1'b0);
            PC_SWEEP:     w = uw(C_SWEEP_ROW_MORE, PC_SWEEP, M_CLR_ROW, D_SWEEP_INC, 1'b0, 1'b0);
            PC_LINK:      w = uw(C_MORE_INNER, PC_ALLOC, M_LINK, D_LINK_ADV, 1'b0, 1'b0);
            PC_LEAF:      w = uw(C_IS_QUERY, PC_FIN, M_NONE, D_SET_HIT, 1'b0, 1'b0);
            PC_UPD:       w = uw(C_ALWAYS, PC_FIN, M_LEAF, D_SET_OK, 1'b0, 1'b0);
            PC_NM:        w = uw(C_ALWAYS, PC_FIN, M_NONE, D_SET_NM, 1'b0, 1'b0);
            PC_OOF:       w = uw(C_ALWAYS, PC_FIN, M_NONE, D_SET_OOF, 1'b0, 1'b0);
            PC_FIN:       w = uw(C_NONE, PC_IDLE, M_NONE, D_NONE, 1'b0, 1'b1);
            default:      w = uw(C_ALWAYS, PC_IDLE, M_NONE, D_NONE, 1'b0, 1'b0);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rptw_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rptw_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/rptw_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module rptw_mem
    import rptw_pkg::*;
#(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [ENT_W-1:0] i_wdata,
    output logic [ENT_W-1:0]      o_rdata
);

    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
    end

    // Registered read, held between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/rptw_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module rptw_seq
    import rptw_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_flags i_flags,
    output t_uword      o_uop
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          uop;
    logic            cond_hit;

    // Fetch the control word and pick the next step
    always_comb begin
        uop = ucode_rom(r_pc);
        case (uop.cond)
            C_NONE:           cond_hit = 1'b0;
            C_ALWAYS:         cond_hit = 1'b1;
            C_NO_ACCEPT:      cond_hit = !i_flags.accept;
            C_SWEEP_ALL_MORE: cond_hit = i_flags.sweep_all_more;
            C_SWEEP_ROW_MORE: cond_hit = i_flags.sweep_row_more;
            C_BAD:            cond_hit = i_flags.bad;
            C_AT_LEAF:        cond_hit = i_flags.at_leaf;
            C_RD_VALID:       cond_hit = i_flags.rd_valid;
            C_NOT_MAP:        cond_hit = i_flags.not_map;
            C_NO_ROOM:        cond_hit = i_flags.no_room;
            C_MORE_INNER:     cond_hit = i_flags.more_inner;
            C_IS_QUERY:       cond_hit = i_flags.is_query;
            default:          cond_hit = 1'b0;
        endcase

        if (uop.fin) begin
            // hold the final step until the result register frees up
            n_pc = i_flags.out_busy ? r_pc : PC_IDLE;
        end else if (cond_hit) begin
            n_pc = uop.target;
        end else begin
            n_pc = r_pc + 4'd1;
        end
    end

    // Step counter; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_CLEAR;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uop = uop;

endmodule

`default_nettype wire

FILE: rtl/rptw_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module rptw_dpath
    import rptw_pkg::*;
#(
    parameter int NUM_FRAMES = 64,
    parameter int LEVELS     = 5
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire t_uword               i_uop,
    output t_flags                    o_flags,
    rptw_chan_if.sink                 i_req,
    rptw_chan_if.source               o_rsp
);

    localparam int FRAME_W = $clog2(NUM_FRAMES);
    localparam int AW      = FRAME_W + IDX_W;
    localparam int DEPTH   = NUM_FRAMES * ENTRIES;
    localparam int CAP     = (NUM_FRAMES < NF_CAP) ? NUM_FRAMES : NF_CAP;

    // Configuration and allocator
    logic [ROOT_W-1:0]  r_root;
    logic [NF_W-1:0]    r_next_free;

    // Request and walk state
    t_cmd               r_cmd;
    logic [VP_W-1:0]    r_vp;
    logic [TF_W-1:0]    r_tf;
    logic               r_unmap;
    logic [FRAME_W-1:0] r_frame;
    logic               r_bad;
    logic [LVL_W-1:0]   r_lvl;
    logic [FRAME_W-1:0] r_nf;
    logic [AW-1:0]      r_sweep;
    t_status            r_stat;
    logic [TF_W-1:0]    r_res;

    // Result register
    logic               r_out_valid;
    t_rsp               r_out;

    // Memory port
    logic               mem_we;
    logic               mem_re;
    logic [AW-1:0]      mem_addr;
    logic [ENT_W-1:0]   mem_wdata;
    logic [ENT_W-1:0]   mem_rdata;

    logic [TF_W-1:0]    ent_frame;
    logic               ent_valid;
    logic               ent_bad;
    logic               root_bad;
    logic [63:0]        root_ext;
    logic [63:0]        nf_ext;
    logic [LVL_W-1:0]   lvl_sh;
    logic [IDX_W-1:0]   lvl_idx;
    logic [LVL_W-1:0]   need;
    logic [NF_W-1:0]    avail;
    logic               accept;
    logic               out_busy;

    assign ent_frame = mem_rdata[ENT_W-1:1];
    assign ent_valid = mem_rdata[0];
    assign ent_bad   = ent_frame >= TF_W'(NUM_FRAMES);
    assign root_ext  = 64'(r_root);
    assign nf_ext    = 64'(r_next_free);
    assign root_bad  = 32'(r_root) >= 32'(NUM_FRAMES);

    assign accept   = i_req.valid && i_uop.rdy;
    assign out_busy = r_out_valid && !o_rsp.ready;

    // Pick the 9-bit index of the current level, highest level first
    always_comb begin
        lvl_sh = LVL_W'(LEVELS - 1) - r_lvl;
        case (lvl_sh)
            3'd0:    lvl_idx = r_vp[8:0];
            3'd1:    lvl_idx = r_vp[17:9];
            3'd2:    lvl_idx = r_vp[26:18];
            3'd3:    lvl_idx = r_vp[35:27];
            3'd4:    lvl_idx = r_vp[44:36];
            default: lvl_idx = '0;
        endcase
    end

    // Frames still needed versus frames the allocator can hand out
    always_comb begin
        need  = LVL_W'(LEVELS - 1) - r_lvl;
        avail = (NF_W'(CAP) > r_next_free) ? (NF_W'(CAP) - r_next_free) : '0;
    end

    // Drive the memory port from the control word
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = {r_frame, lvl_idx};
        mem_wdata = '0;
        case (i_uop.mem)
            M_NONE: begin
            end
            M_READ: begin
                mem_re = 1'b1;
            end
            M_CLR_ALL: begin
                mem_we   = 1'b1;
                mem_addr = r_sweep;
            end
            M_CLR_ROW: begin
                mem_we   = 1'b1;
                mem_addr = {r_nf, r_sweep[IDX_W-1:0]};
            end
            M_LINK: begin
                mem_we    = 1'b1;
                mem_wdata = {TF_W'(r_nf), 1'b1};
            end
            M_LEAF: begin
                mem_we    = 1'b1;
                mem_wdata = r_unmap ? '0 : {r_tf, 1'b1};
            end
            default: begin
            end
        endcase
    end

    rptw_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // Status flags for the sequencer
    always_comb begin
        o_flags.accept         = accept;
        o_flags.sweep_all_more = r_sweep != AW'(DEPTH - 1);
        o_flags.sweep_row_more = r_sweep[IDX_W-1:0] != IDX_W'(ENTRIES - 1);
        o_flags.bad            = r_bad;
        o_flags.at_leaf        = r_lvl == LVL_W'(LEVELS - 1);
        o_flags.rd_valid       = ent_valid;
        o_flags.not_map        = (r_cmd == CMD_QUERY) || r_unmap;
        o_flags.no_room        = NF_W'(need) > avail;
        o_flags.more_inner     = ({1'b0, r_lvl} + 4'd1) < 4'(LEVELS - 1);
        o_flags.is_query       = r_cmd == CMD_QUERY;
        o_flags.out_busy       = out_busy;
    end

    // Configuration writes and frame allocation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root      <= '0;
            r_next_free <= NF_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ROOT_FRAME: r_root      <= i_cfg_data[ROOT_W-1:0];
                CFG_FIRST_FREE: r_next_free <= i_cfg_data;
                default: begin
                end
            endcase
        end else if (i_uop.dp == D_ALLOC) begin
            r_next_free <= r_next_free + NF_W'(1);
        end
    end

    // Sweep address for the clearing passes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else begin
            case (i_uop.dp)
                D_SWEEP_INC: r_sweep <= r_sweep + AW'(1);
                D_ALLOC:     r_sweep <= '0;
                default: begin
                end
            endcase
        end
    end

    // Walk registers
    always_ff @(posedge i_clk) begin
        case (i_uop.dp)
            D_LOAD_REQ: begin
                if (accept) begin
                    r_cmd   <= i_req.data.command;
                    r_vp    <= i_req.data.virtual_page;
                    r_tf    <= i_req.data.target_frame;
                    r_unmap <= i_req.data.unmap;
                    r_frame <= root_ext[FRAME_W-1:0];
                    r_bad   <= root_bad;
                    r_lvl   <= '0;
                end
            end
            D_LOAD_ENTRY: begin
                // follow the pointer only when the entry is valid
                if (ent_valid) begin
                    r_frame <= ent_frame[FRAME_W-1:0];
                    r_bad   <= ent_bad;
                    r_lvl   <= r_lvl + LVL_W'(1);
                end
            end
            D_ALLOC: begin
                r_nf <= nf_ext[FRAME_W-1:0];
            end
            D_LINK_ADV: begin
                r_frame <= r_nf;
                r_lvl   <= r_lvl + LVL_W'(1);
            end
            D_SET_HIT: begin
                if (ent_valid) begin
                    r_stat <= ST_OK;
                    r_res  <= ent_frame;
                end else begin
                    r_stat <= ST_NOT_MAPPED;
                    r_res  <= '0;
                end
            end
            D_SET_OK: begin
                r_stat <= ST_OK;
                r_res  <= '0;
            end
            D_SET_NM: begin
                r_stat <= ST_NOT_MAPPED;
                r_res  <= '0;
            end
            D_SET_OOF: begin
                r_stat <= ST_NO_FRAMES;
                r_res  <= '0;
            end
            default: begin
            end
        endcase
    end

    // Result register: load on the final step, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_uop.fin && !out_busy) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_uop.fin && !out_busy) begin
            r_out.status       <= r_stat;
            r_out.result_frame <= r_res;
        end
    end

    assign i_req.ready = i_uop.rdy;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

`default_nettype wire

FILE: rtl/radix_page_table_walker.sv
// A walk passes each inner level through the bad-pointer check, entry read and evaluate
// steps; a map that builds missing levels takes a fresh frame for each and clears its
// whole row before linking it in.
// One request at a time: the next is accepted in the cycle the result appears, or later
// while an earlier result still waits in the output register.
// Reset: root frame 0, allocator at frame 1, then a clear of all NUM_FRAMES*512 table entries.
`timescale 1ns / 1ps
`default_nettype none

module radix_page_table_walker
    import rptw_pkg::*;
#(
    parameter int NUM_FRAMES = 64,
    parameter int LEVELS     = 5
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    rptw_chan_if.sink                 i_req,
    rptw_chan_if.source               o_rsp
);

    t_uword uop;
    t_flags flags;

    rptw_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uop   (uop)
    );

    rptw_dpath #(
        .NUM_FRAMES (NUM_FRAMES),
        .LEVELS     (LEVELS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_uop      (uop),
        .o_flags    (flags),
        .i_req      (i_req),
        .o_rsp      (o_rsp)
    );

endmodule

`default_nettype wire

FILE: verif/radix_page_table_walker_tb.sv
`timescale 1ns / 1ps

module radix_page_table_walker_tb;
    import rptw_pkg::*;

    localparam int NFR  = 64;
    localparam int LVLS = 5;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    rptw_chan_if #(.t_payload(t_req)) req_if ();
    rptw_chan_if #(.t_payload(t_rsp)) rsp_if ();

    radix_page_table_walker #(
        .NUM_FRAMES(NFR),
        .LEVELS    (LVLS)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_req     (req_if),
        .o_rsp     (rsp_if)
    );

    // Shadow copy of the frame memory, root pointer and bump allocator
    bit   [63:0]       frame_mem [NFR*ENTRIES];
    logic [ROOT_W-1:0] root_sel   = '0;
    logic [NF_W-1:0]   alloc_next = NF_W'(1);

    t_req              requests_todo [$];
    t_rsp              walks_due [$];
    logic [VP_W-1:0]   mapped_pages [$];

    int                walk_fails = 0;
    int                rsp_count  = 0;
    int                hold_left  = 0;
    bit                hold_done  = 1'b0;
    logic              calm;

    // No random idling on either side for a stretch of the run
    assign calm = (rsp_count >= 900) && (rsp_count < 1200);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200_000_000;
        $display("radix_page_table_walker: mismatch");
        $finish;
    end

    // Entry address of the level's index inside a table frame
    function automatic int slot(input logic [TF_W-1:0] fr, input logic [VP_W-1:0] vp,
                                input int lvl);
        return int'(fr % NFR) * ENTRIES + int'(9'(vp >> (IDX_W * (LVLS - 1 - lvl))));
    endfunction

    // Walk the shadow tables for one request, apply its update, return its response
    function automatic t_rsp walk_table(input t_req r);
        t_rsp            res;
        bit   [63:0]     ent;
        logic [TF_W-1:0] fr;
        logic [NF_W-1:0] nf;
        int              lvl;
        int              cap;
        int              avail;
        bit              bad;
        bit              stop;
        res.status       = ST_OK;
        res.result_frame = '0;
        fr   = TF_W'(root_sel);
        lvl  = 0;
        bad  = 1'b0;
        stop = 1'b0;
        // descend inner levels until a hole, a bad pointer or the leaf table
        while (lvl < LVLS - 1 && !stop) begin
            if (fr >= NFR) begin
                bad  = 1'b1;
                stop = 1'b1;
            end else begin
                ent = frame_mem[slot(fr, r.virtual_page, lvl)];
                if (!ent[0]) begin
                    stop = 1'b1;
                end else begin
                    fr = ent[63:12];
                    lvl++;
                end
            end
        end
        if (bad || fr >= NFR) begin
            res.status = ST_NOT_MAPPED;
            return res;
        end

        if (r.command == CMD_QUERY) begin
            if (lvl < LVLS - 1) begin
                res.status = ST_NOT_MAPPED;
            end else begin
                ent = frame_mem[slot(fr, r.virtual_page, lvl)];
                if (!ent[0]) res.status = ST_NOT_MAPPED;
                else res.result_frame = ent[63:12];
            end
        end else if (r.unmap) begin
            // clear the leaf whether or not it was valid
            if (lvl < LVLS - 1) res.status = ST_NOT_MAPPED;
            else frame_mem[slot(fr, r.virtual_page, lvl)] = '0;
        end else begin
            cap   = (NFR < NF_CAP) ? NFR : NF_CAP;
            avail = (cap > int'(alloc_next)) ? cap - int'(alloc_next) : 0;
            if (LVLS - 1 - lvl > avail) begin
                res.status = ST_NO_FRAMES;
            end else begin
                // zero each fresh frame before linking it in
                while (lvl < LVLS - 1) begin
                    nf         = alloc_next;
                    alloc_next = alloc_next + 1'b1;
                    for (int i = 0; i < ENTRIES; i++) frame_mem[int'(nf) * ENTRIES + i] = '0;
                    frame_mem[slot(fr, r.virtual_page, lvl)] = (64'(nf) << 12) | 64'd1;
                    fr = TF_W'(nf);
                    lvl++;
                end
                frame_mem[slot(fr, r.virtual_page, lvl)] = {r.target_frame, 12'h001};
            end
        end
        return res;
    endfunction

    function automatic t_req mk(input t_cmd cmd, input logic [VP_W-1:0] vp,
                                input logic [TF_W-1:0] tf, input logic um);
        t_req r;
        r.command      = cmd;
        r.virtual_page = vp;
        r.target_frame = tf;
        r.unmap        = um;
        return r;
    endfunction

    function automatic logic [TF_W-1:0] rand_frame();
        if ($urandom_range(0, 99) < 30) return TF_W'($urandom_range(0, NFR - 1));
        return TF_W'({$urandom, $urandom});
    endfunction

    function automatic logic [VP_W-1:0] pool_page();
        if (mapped_pages.size() == 0) return VP_W'({$urandom, $urandom});
        return mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
    endfunction

    // Keep the upper indices of a known page and redraw the lower ones
    function automatic logic [VP_W-1:0] vary_page(input logic [VP_W-1:0] base);
        logic [VP_W-1:0] vp;
        int              top;
        int              roll;
        vp   = base;
        roll = $urandom_range(0, 99);
        top  = (roll < 55) ? 4 : (roll < 75) ? 3 : $urandom_range(0, 2);
        for (int l = top; l < LVLS; l++) vp[IDX_W * (LVLS - 1 - l) +: IDX_W] = 9'($urandom);
        return vp;
    endfunction

    function automatic void remember(input logic [VP_W-1:0] vp);
        mapped_pages.push_back(vp);
        if (mapped_pages.size() > 48) mapped_pages.delete($urandom_range(0, 47));
    endfunction

    // Mostly queries and updates around pages already mapped, some noise
    function automatic t_req make_request();
        t_req r;
        int   roll;
        roll = $urandom_range(0, 99);
        r = mk(CMD_QUERY, pool_page(), rand_frame(), 1'($urandom));
        if (roll >= 30 && roll < 45) begin
            r.virtual_page = vary_page(pool_page());
        end else if (roll >= 45 && roll < 75) begin
            r.command      = CMD_UPDATE;
            r.unmap        = 1'b0;
            r.virtual_page = vary_page(pool_page());
            remember(r.virtual_page);
        end else if (roll >= 75 && roll < 87) begin
            r.command = CMD_UPDATE;
            r.unmap   = 1'b1;
            if (roll >= 83) r.virtual_page = vary_page(pool_page());
        end else if (roll >= 87) begin
            r.command      = t_cmd'($urandom_range(0, 1));
            r.virtual_page = VP_W'({$urandom, $urandom});
            if (r.command == CMD_UPDATE && !r.unmap) remember(r.virtual_page);
        end
        return r;
    endfunction

    // Hold until every pending transaction has come back, then let the sequencer settle
    task automatic wait_drained();
        @(negedge i_clk);
        while (requests_todo.size() != 0 || req_if.valid || walks_due.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_reg(input t_cfg_idx idx, input int value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_W'(value);
        case (idx)
            CFG_ROOT_FRAME: root_sel   = ROOT_W'(value);
            CFG_FIRST_FREE: alloc_next = NF_W'(value);
            default: ;
        endcase
    endtask

    task automatic run_phase(input int root, input int first_free, input int count);
        set_reg(CFG_ROOT_FRAME, root);
        set_reg(CFG_FIRST_FREE, first_free);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
        for (int i = 0; i < count / 2; i++) requests_todo.push_back(make_request());
        // pause the sender mid-phase until the block is empty
        wait_drained();
        @(negedge i_clk);
        for (int i = count / 2; i < count; i++) requests_todo.push_back(make_request());
        wait_drained();
    endtask

    // Drive request transactions from the pending queue; predict each one on accept
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) walks_due.push_back(walk_table(req_if.data));
            if (!req_if.valid || req_if.ready) begin
                if (requests_todo.size() != 0 && (calm || $urandom_range(0, 99) >= 7)) begin
                    req_if.data  <= requests_todo.pop_front();
                    req_if.valid <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Count down one long back-pressure stretch on the response side
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && rsp_count == 500) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_left != 0) rsp_if.ready <= 1'b0;
        else rsp_if.ready <= calm || ($urandom_range(0, 99) >= 7);
    end

    // Check each response transaction against the oldest prediction
    always @(posedge i_clk) begin : check_rsp
        t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            rsp_count <= rsp_count + 1;
            if (walks_due.size() == 0) begin
                walk_fails++;
                if (walk_fails <= 10)
                    $display("response %0d arrived with nothing outstanding", rsp_count);
            end else begin
                want = walks_due.pop_front();
                if (rsp_if.data.status !== want.status ||
                    rsp_if.data.result_frame !== want.result_frame) begin
                    walk_fails++;
                    if (walk_fails <= 10)
                        $display("response %0d: status exp %0d got %0d, frame exp %h got %h",
                                 rsp_count, want.status, rsp_if.data.status,
                                 want.result_frame, rsp_if.data.result_frame);
                end
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_ROOT_FRAME;
        cfg_data     = '0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty tables, then full walks at both ends of the page and frame ranges
        @(negedge i_clk);
        requests_todo.push_back(mk(CMD_QUERY,  '0, '0, 1'b0));
        requests_todo.push_back(mk(CMD_UPDATE, '0, '0, 1'b1));
        requests_todo.push_back(mk(CMD_UPDATE, '0, '1, 1'b0));
        requests_todo.push_back(mk(CMD_QUERY,  '0, '0, 1'b0));
        requests_todo.push_back(mk(CMD_UPDATE, '1, '0, 1'b0));
        requests_todo.push_back(mk(CMD_QUERY,  '1, '1, 1'b0));
        requests_todo.push_back(mk(CMD_QUERY,  '0, '1, 1'b1));
        requests_todo.push_back(mk(CMD_UPDATE, '0, TF_W'(5), 1'b0));
        requests_todo.push_back(mk(CMD_QUERY,  '0, '0, 1'b0));
        requests_todo.push_back(mk(CMD_UPDATE, '1, '0, 1'b1));
        requests_todo.push_back(mk(CMD_QUERY,  '1, '0, 1'b0));
        requests_todo.push_back(mk(CMD_UPDATE, '1, '1, 1'b1));
        requests_todo.push_back(mk(CMD_UPDATE, VP_W'(1), 52'hA_AAAA_AAAA_AAAA, 1'b0));
        requests_todo.push_back(mk(CMD_QUERY,  VP_W'(1), '0, 1'b0));
        requests_todo.push_back(mk(CMD_QUERY,  VP_W'(2), '0, 1'b0));
        wait_drained();

        // Root on a leaf table: entries read as pointers run past the frame
        // range; allocator exhausted so fresh paths run out of frames
        set_reg(CFG_ROOT_FRAME, 4);
        set_reg(CFG_FIRST_FREE, NFR);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
        requests_todo.push_back(mk(CMD_QUERY,  '0, '0, 1'b0));
        requests_todo.push_back(mk(CMD_QUERY,  VP_W'(1) << 36, '0, 1'b0));
        requests_todo.push_back(mk(CMD_UPDATE, VP_W'(1) << 36, TF_W'(3), 1'b0));
        requests_todo.push_back(mk(CMD_UPDATE, VP_W'(1) << 36, '0, 1'b1));
        requests_todo.push_back(mk(CMD_UPDATE, VP_W'(2) << 36, TF_W'(9), 1'b0));
        wait_drained();

        mapped_pages.push_back('0);
        mapped_pages.push_back('1);
        run_phase(63, 0, 360);
        run_phase(0, 0, 360);
        run_phase($urandom_range(1, 62), NFR, 200);
        run_phase(0, 1, 440);
        run_phase($urandom_range(0, 63), $urandom_range(0, NFR), 440);

        repeat (20) @(posedge i_clk);
        if (walk_fails == 0 && walks_due.size() == 0) begin
            $display("radix_page_table_walker: match");
        end else begin
            $display("radix_page_table_walker: mismatch");
        end
        $finish;
    end

endmodule
